FILE: hw/rtl/fmc_pkg.sv
// ----------------------------------------------------------------------------
// fmc_pkg: shared types, constants and operator functions
// Payload types, register indexes, the log-sine and exponent ROM contents
// (built at elaboration with Q60 fixed-point arithmetic) and the two
// halves of one FM operator evaluation.
// ----------------------------------------------------------------------------
`default_nettype none

package fmc_pkg;

   // ---------------------------------------------------------------- params
   localparam int FmcQueueDepth = 2;

   // ------------------------------------------------------- register indexes
   localparam logic [7:0] RegModTotalLevel = 8'd0;
   localparam logic [7:0] RegFeedback      = 8'd1;
   localparam logic [7:0] RegModKeyScale   = 8'd2;
   localparam logic [7:0] RegCarKeyScale   = 8'd3;
   localparam logic [7:0] RegVolume        = 8'd4;
   localparam logic [7:0] RegModFlags      = 8'd5;
   localparam logic [7:0] RegCarFlags      = 8'd6;

   // envelope bits 6..2 all set stops the operator
   localparam logic [4:0] EnvStop    = 5'h1F;
   localparam logic [8:0] AttMax     = 9'd127;
   localparam logic [11:0] LogsinMax = 12'hFFF;
   localparam logic [4:0] ShiftLimit = 5'd12;

   // ------------------------------------------------------------------ types
   typedef struct packed {
      logic [9:0] phase;
      logic [6:0] mod_envelope;
      logic [6:0] car_envelope;
      logic [3:0] am_level;
   } req_type;

   typedef struct packed {
      logic signed [8:0] sample;
   } rsp_type;

   typedef struct packed {
      logic [7:0] index;
      logic [7:0] value;
   } csr_type;

   typedef struct packed {
      logic [5:0] mod_total_level;
      logic [2:0] feedback;
      logic [6:0] mod_key_scale;
      logic [6:0] car_key_scale;
      logic [3:0] volume;
      logic [1:0] mod_flags;
      logic [1:0] car_flags;
   } cfg_type;

   typedef struct packed {
      logic [9:0]  phase;
      logic [11:0] mod_out;
      logic [6:0]  car_envelope;
      logic [3:0]  am_level;
   } queue_item_type;

   // log-domain operator value: stop flag, sign, attenuated log magnitude
   typedef struct packed {
      logic        stop;
      logic        sign;
      logic [12:0] mag;
   } log_type;

   // ------------------------------------------------------ ROM construction
   localparam logic [63:0] OneQ60 = 64'h1000_0000_0000_0000;
   localparam logic [63:0] PiQ60  = 64'h3243_F6A8_885A_308D;
   localparam logic [63:0] Ln2Q60 = 64'h0B17_217F_7D1C_F79B;

   // Q60 product, rounded, kept to 64 bits
   function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p + (128'd1 << 59);
      return p[123:60];
   endfunction

   // round(-log2(sin((i+0.5)*pi/512))*256)
   function automatic logic [255:0][11:0] build_logsin();
      logic [255:0][11:0] tbl;
      logic [63:0] x, x2, term, s, k, frac, t;
      for (int i = 0; i < 256; i++) begin
         x    = 64'(2 * i + 1) * (PiQ60 >> 10);
         x2   = qmul(x, x);
         term = x;
         s    = x;
         for (int n = 1; n < 20; n++) begin
            term = qmul(term, x2) / 64'((2 * n) * (2 * n + 1));
            if (n[0]) begin
               s = s - term;
            end else begin
               s = s + term;
            end
         end
         k    = '0;
         frac = '0;
         if (s == '0) begin
            s = 64'd1;
         end
         for (int j = 0; j < 64; j++) begin
            if (s < OneQ60) begin
               s = s << 1;
               k = k + 64'd1;
            end
         end
         for (int b = 0; b < 40; b++) begin
            s    = qmul(s, s);
            frac = frac << 1;
            if (s >= (OneQ60 << 1)) begin
               s    = s >> 1;
               frac = frac | 64'd1;
            end
         end
         t      = (k << 40) - frac;
         tbl[i] = 12'((t + (64'd1 << 31)) >> 32);
      end
      return tbl;
   endfunction

   // round((2^(i/256)-1)*1024)
   function automatic logic [255:0][9:0] build_exp();
      logic [255:0][9:0] tbl;
      logic [63:0] y, e, et;
      for (int i = 0; i < 256; i++) begin
         y  = 64'(i) * (Ln2Q60 >> 8);
         e  = OneQ60;
         et = OneQ60;
         for (int n = 1; n < 30; n++) begin
            et = qmul(et, y) / 64'(n);
            e  = e + et;
         end
         tbl[i] = 10'(((e - OneQ60) + (64'd1 << 49)) >> 50);
      end
      return tbl;
   endfunction

   localparam logic [255:0][11:0] LogsinRom = build_logsin();
   localparam logic [255:0][9:0]  ExpRom    = build_exp();

   // -------------------------------------------------------- operator halves
   // phase -> quarter-wave log-sine plus 16 * clamped attenuation
   function automatic log_type op_log(logic [9:0] phase, logic [1:0] flags,
                                      logic [6:0] env, logic [7:0] level,
                                      logic [3:0] am);
      log_type    res;
      logic [7:0] idx;
      logic [11:0] s;
      logic [8:0] att_sum;
      logic [6:0] att;
      idx = phase[7:0] ^ {8{phase[8]}};
      s   = LogsinRom[idx];
      if (phase[9] && flags[1]) begin
         s = LogsinMax;
      end
      att_sum  = 9'(level) + 9'(env) + (flags[0] ? 9'(am) : 9'd0);
      att      = (att_sum > AttMax) ? AttMax[6:0] : att_sum[6:0];
      res.stop = (env[6:2] == EnvStop);
      res.sign = phase[9];
      res.mag  = 13'(s) + {2'b00, att, 4'b0000};
      return res;
   endfunction

   // log value -> ones-complement linear value
   function automatic logic signed [12:0] op_exp(log_type l);
      logic [11:0] t;
      logic [4:0]  sh;
      logic [11:0] mag;
      logic [12:0] r;
      t   = {1'b1, ExpRom[~l.mag[7:0]], 1'b0};
      sh  = l.mag[12:8];
      mag = (sh < ShiftLimit) ? (t >> sh) : 12'd0;
      r   = {1'b0, mag};
      if (l.sign) begin
         r = ~r;
      end
      if (l.stop) begin
         r = '0;
      end
      return signed'(r);
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fmc_stream_if.sv
// ----------------------------------------------------------------------------
// fmc_stream_if: valid/ready channel
// One transaction moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface fmc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/fmc_csr.sv
// ----------------------------------------------------------------------------
// fmc_csr: configuration registers
// Write-only register file; unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module fmc_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   fmc_stream_if.sink       csr_chan,
   output fmc_pkg::cfg_type cfg
);
   import fmc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.data.index)
            RegModTotalLevel: cfg_in.mod_total_level = csr_chan.data.value[5:0];
            RegFeedback:      cfg_in.feedback        = csr_chan.data.value[2:0];
            RegModKeyScale:   cfg_in.mod_key_scale   = csr_chan.data.value[6:0];
            RegCarKeyScale:   cfg_in.car_key_scale   = csr_chan.data.value[6:0];
            RegVolume:        cfg_in.volume          = csr_chan.data.value[3:0];
            RegModFlags:      cfg_in.mod_flags       = csr_chan.data.value[1:0];
            RegCarFlags:      cfg_in.car_flags       = csr_chan.data.value[1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/fmc_front.sv
// ----------------------------------------------------------------------------
// fmc_front: request intake and modulator
// Takes a request, forms the modulator phase with self feedback, does the
// log-sine half in the intake cycle and the exponent half on the way into
// the queue. Holds the last two modulator outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module fmc_front (
   input  wire logic        clock,
   input  wire logic        reset,
   input  fmc_pkg::cfg_type cfg,
   fmc_stream_if.sink       req_chan,
   fmc_stream_if.source     queue_chan,
   output logic             busy
);
   import fmc_pkg::*;

   logic              a_valid_ff, a_valid_in;
   log_type           a_log_ff, a_log_in;
   logic [9:0]        a_phase_ff;
   logic [6:0]        a_car_env_ff;
   logic [3:0]        a_am_ff;
   logic [11:0]       mod_last_ff, mod_last_in;
   logic [11:0]       mod_prev_ff, mod_prev_in;

   logic signed [12:0] fb_sum;
   logic signed [12:0] fb_term;
   logic [2:0]         fb_shift;
   logic [9:0]         mod_phase;
   logic [7:0]         mod_level;
   logic signed [12:0] mod_full;
   logic [11:0]        mod_out;
   logic               a_open;
   logic               a_fire;
   logic               req_fire;

   // feedback term from the last two modulator outputs
   always_comb begin
      fb_sum    = signed'({mod_last_ff[11], mod_last_ff})
                + signed'({mod_prev_ff[11], mod_prev_ff});
      fb_shift  = 3'(4'd8 - {1'b0, cfg.feedback});
      fb_term   = fb_sum >>> fb_shift;
      mod_phase = req_chan.data.phase - 10'd1
                + ((cfg.feedback != 3'd0) ? fb_term[9:0] : 10'd0);
      mod_level = {1'b0, cfg.mod_total_level, 1'b0} + {1'b0, cfg.mod_key_scale};
      a_log_in  = op_log(mod_phase, cfg.mod_flags, req_chan.data.mod_envelope,
                         mod_level, req_chan.data.am_level);
   end

   assign mod_full = op_exp(a_log_ff);
   assign mod_out  = mod_full[12:1];

   assign a_open   = !a_valid_ff || queue_chan.ready;
   assign a_fire   = a_valid_ff && queue_chan.ready;
   // with feedback on, the next phase needs this item's output first
   assign req_chan.ready = a_open && ((cfg.feedback == 3'd0) || !a_valid_ff);
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign a_valid_in  = req_fire || (a_valid_ff && !queue_chan.ready);
   assign mod_last_in = a_fire ? mod_out : mod_last_ff;
   assign mod_prev_in = a_fire ? mod_last_ff : mod_prev_ff;

   assign queue_chan.valid             = a_valid_ff;
   assign queue_chan.data.phase        = a_phase_ff;
   assign queue_chan.data.mod_out      = mod_out;
   assign queue_chan.data.car_envelope = a_car_env_ff;
   assign queue_chan.data.am_level     = a_am_ff;

   assign busy = a_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         mod_last_ff <= '0;
         mod_prev_ff <= '0;
      end else begin
         a_valid_ff  <= a_valid_in;
         mod_last_ff <= mod_last_in;
         mod_prev_ff <= mod_prev_in;
      end
      if (req_fire) begin
         a_log_ff     <= a_log_in;
         a_phase_ff   <= req_chan.data.phase;
         a_car_env_ff <= req_chan.data.car_envelope;
         a_am_ff      <= req_chan.data.am_level;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/fmc_fifo.sv
// ----------------------------------------------------------------------------
// fmc_fifo: short queue between front and back
// Register-based FIFO; lets the modulator and the carrier stall separately.
// ----------------------------------------------------------------------------
`default_nettype none

module fmc_fifo #(
   parameter int Depth = fmc_pkg::FmcQueueDepth
) (
   input  wire logic    clock,
   input  wire logic    reset,
   fmc_stream_if.sink   in_chan,
   fmc_stream_if.source out_chan
);
   import fmc_pkg::*;

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   queue_item_type         mem_ff [Depth];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   push;
   logic                   pop;

   assign in_chan.ready  = (count_ff != CountWidth'(Depth));
   assign out_chan.valid = (count_ff != '0);
   assign out_chan.data  = mem_ff[rd_ptr_ff];

   assign push = in_chan.valid && in_chan.ready;
   assign pop  = out_chan.valid && out_chan.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_chan.data;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/fmc_back.sv
// ----------------------------------------------------------------------------
// fmc_back: carrier evaluation and response register
// Carrier phase from the queued modulator output, log-sine half in one
// stage, exponent half and the final shift into the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module fmc_back (
   input  wire logic        clock,
   input  wire logic        reset,
   input  fmc_pkg::cfg_type cfg,
   fmc_stream_if.sink       queue_chan,
   fmc_stream_if.source     rsp_chan
);
   import fmc_pkg::*;

   logic               b_valid_ff, b_valid_in;
   log_type            b_log_ff, b_log_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [8:0]  rsp_sample_ff, rsp_sample_in;

   logic [9:0]         car_phase;
   logic [7:0]         car_level;
   logic signed [12:0] car_full;
   logic               out_open;
   logic               b_open;

   always_comb begin
      car_phase = queue_chan.data.phase + {queue_chan.data.mod_out[8:0], 1'b0};
      car_level = {1'b0, cfg.volume, 3'b000} + {1'b0, cfg.car_key_scale};
      b_log_in  = op_log(car_phase, cfg.car_flags, queue_chan.data.car_envelope,
                         car_level, queue_chan.data.am_level);
   end

   assign car_full      = op_exp(b_log_ff);
   assign rsp_sample_in = car_full[12:4];

   assign out_open = !rsp_valid_ff || rsp_chan.ready;
   assign b_open   = !b_valid_ff || out_open;

   assign queue_chan.ready = b_open;
   assign b_valid_in   = b_open ? queue_chan.valid : b_valid_ff;
   assign rsp_valid_in = out_open ? b_valid_ff : rsp_valid_ff;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.data.sample = rsp_sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (b_open) begin
         b_log_ff <= b_log_in;
      end
      if (out_open) begin
         rsp_sample_ff <= rsp_sample_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/fm_two_operator_channel_top.sv
// ----------------------------------------------------------------------------
// fm_two_operator_channel_top: two-operator FM channel
// Modulator with self feedback driving a carrier, both through log-sine and
// exponent ROMs; one signed channel sample per request.
//
//   channel    dir  payload                                        role
//   req_chan   in   phase, mod_envelope, car_envelope, am_level    sample request
//   rsp_chan   out  sample                                         channel output
//   csr_chan   in   index, value                                   register write
//
// One request per cycle with feedback off, when the response side does not
// stall; with feedback on, a request is taken only once the modulator stage
// is empty, since the modulator output register closes the feedback loop.
// Reset is synchronous; no clearing pass (ROMs are logic).
// A stalled response backs up through the queue into the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module fm_two_operator_channel_top #(
   parameter int QueueDepth = fmc_pkg::FmcQueueDepth
) (
   input wire logic     clock,
   input wire logic     reset,
   fmc_stream_if.sink   req_chan,
   fmc_stream_if.source rsp_chan,
   fmc_stream_if.sink   csr_chan
);
   import fmc_pkg::*;

   cfg_type cfg;
   logic    front_busy;

   fmc_stream_if #(.payload_type(queue_item_type)) queue_in ();
   fmc_stream_if #(.payload_type(queue_item_type)) queue_out ();

   fmc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   fmc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_chan   (req_chan),
      .queue_chan (queue_in),
      .busy       (front_busy)
   );

   fmc_fifo #(.Depth(QueueDepth)) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .in_chan  (queue_in),
      .out_chan (queue_out)
   );

   fmc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .queue_chan (queue_out),
      .rsp_chan   (rsp_chan)
   );

   // no response right out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("response valid after reset");

   // feedback loop: no intake while the modulator stage is occupied
   a_fb_hazard: assert property (@(posedge clock) disable iff (reset)
      (front_busy && (cfg.feedback != 3'd0)) |-> !req_chan.ready)
      else $error("request taken during feedback hazard");

   // an accepted request occupies the modulator stage next cycle
   a_intake: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> front_busy)
      else $error("accepted request lost at intake");

endmodule

`default_nettype wire
